// ----- rtl/core/qaa_pkg.sv -----
// shared types and constants for the quaternion to alt/az core
package qaa_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned AccBits     = 32;
  localparam int unsigned QuatBits    = 16;
  // width of direction and cordic vector components
  localparam int unsigned VecBits     = 52;
  localparam int unsigned ProdBits    = 36;
  localparam logic [37:0] NearZeroQ36 = 38'd68719;
  localparam logic [16:0] InvGainQ16  = 17'd39797;

  localparam logic [1:0] CfgOffsetW = 2'd0;
  localparam logic [1:0] CfgOffsetX = 2'd1;
  localparam logic [1:0] CfgOffsetY = 2'd2;
  localparam logic [1:0] CfgOffsetZ = 2'd3;

  typedef struct packed {
    logic signed [QuatBits-1:0] w;
    logic signed [QuatBits-1:0] x;
    logic signed [QuatBits-1:0] y;
    logic signed [QuatBits-1:0] z;
  } quat_t;

  typedef struct packed {
    logic                        active;
    logic                        zero;
    logic signed [VecBits-1:0]   x;
    logic signed [VecBits-1:0]   y;
    logic [AccBits-1:0]          acc;
  } cordic_t;

  function automatic logic [AccBits-1:0] atan_turn(input logic [4:0] i);
    logic [AccBits-1:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/qaa_if.sv -----
// valid/ready stream interfaces for sensor requests and angle results
interface qaa_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sensor_w;
  logic [15:0] sensor_x;
  logic [15:0] sensor_y;
  logic [15:0] sensor_z;
  modport source (output valid, sensor_w, sensor_x, sensor_y, sensor_z, input ready);
  modport sink (input valid, sensor_w, sensor_x, sensor_y, sensor_z, output ready);
endinterface

interface qaa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] altitude;
  logic [15:0] azimuth;
  logic        scope_east;
  modport source (output valid, altitude, azimuth, scope_east, input ready);
  modport sink (input valid, altitude, azimuth, scope_east, output ready);
endinterface

// ----- rtl/core/qaa_cordic_cell.sv -----
// one vectoring cordic rotation step, registered
module qaa_cordic_cell
  import qaa_pkg::*;
#(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  localparam logic [4:0] StepIdx = 5'(Step);

  cordic_t cell_d, cell_q;
  logic signed [VecBits-1:0] xs, ys;

  always_comb begin
    xs = cell_i.x >>> Step;
    ys = cell_i.y >>> Step;
    cell_d = cell_i;
    if (cell_i.active) begin
      if (cell_i.y > 0) begin
        cell_d.x   = cell_i.x + ys;
        cell_d.y   = cell_i.y - xs;
        cell_d.acc = cell_i.acc + atan_turn(StepIdx);
      end else begin
        cell_d.x   = cell_i.x - ys;
        cell_d.y   = cell_i.y + xs;
        cell_d.acc = cell_i.acc - atan_turn(StepIdx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- rtl/core/qaa_cordic_chain.sv -----
// chain of cordic cells giving angle and raw magnitude of a vector
module qaa_cordic_chain
  import qaa_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [VecBits-1:0] x_i,
  input  logic signed [VecBits-1:0] y_i,
  output logic [AccBits-1:0]        acc_o,
  output logic signed [VecBits-1:0] mag_o
);

  cordic_t chain [CordicSteps+1];

  // pre-rotation into the right half plane
  always_comb begin
    chain[0].zero   = (x_i == '0) && (y_i == '0);
    chain[0].active = !chain[0].zero;
    if (x_i < 0) begin
      chain[0].x   = -x_i;
      chain[0].y   = -y_i;
      chain[0].acc = 32'h80000000;
    end else begin
      chain[0].x   = x_i;
      chain[0].y   = y_i;
      chain[0].acc = '0;
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    qaa_cordic_cell #(.Step(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  assign acc_o = chain[CordicSteps].zero ? '0 : chain[CordicSteps].acc;
  assign mag_o = chain[CordicSteps].zero ? '0 : chain[CordicSteps].x;

endmodule

// ----- rtl/core/quaternion_to_alt_az_core.sv -----
// quaternion to altitude/azimuth core: top level
// Usage: sensor quaternions (signed 1.14) arrive on in_req as valid/ready
// requests; each gives one result on out_res: altitude, azimuth (binary
// angles of 2^-ANGLE_BITS turn) and scope_east from the raw roll.
// The offset quaternion is set by cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle (unchecked by the block); index 0..3 = w, x, y, z.
// Throughput: one request per cycle while results are taken. The pipe is
// two chained 30-cell cordic rows (azimuth, then altitude) plus 3 multiply
// stages, 2 magnitude stages and the output register.
// The whole pipe advances together; when the receiver stalls with a result
// held, the pipe freezes and in_req.ready drops.
// Reset clears all valid bits and loads the identity offset.
module quaternion_to_alt_az_core
  import qaa_pkg::*;
#(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  qaa_in_if.sink      in_req,
  qaa_out_if.source   out_res
);

  localparam int unsigned Lat = 3 + CordicSteps + 2 + CordicSteps + 1;
  localparam int unsigned Shift = AccBits - ANGLE_BITS;
  localparam logic [AccBits-1:0] RoundHalf = AccBits'(1) << (Shift - 1);
  localparam logic signed [QuatBits-1:0] OneQ = QuatBits'(1 << QUAT_FRAC_BITS);

  quat_t off_q;
  logic  en;
  logic [Lat-1:0] vld_q;

  assign en = !out_res.valid || out_res.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '{w: OneQ, x: '0, y: '0, z: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOffsetW: off_q.w <= cfg_data_i;
        CfgOffsetX: off_q.x <= cfg_data_i;
        CfgOffsetY: off_q.y <= cfg_data_i;
        CfgOffsetZ: off_q.z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_req.valid};
    end
  end
  assign out_res.valid = vld_q[Lat-1];

  // stage 1: quaternion product terms
  logic signed [31:0] t_q [16];
  logic signed [31:0] sx2_q, sy2_q;
  logic signed [15:0] aw, ax, ay, az, bw, bx, by, bz;
  assign aw = off_q.w; assign ax = off_q.x; assign ay = off_q.y; assign az = off_q.z;
  assign bw = in_req.sensor_w; assign bx = in_req.sensor_x;
  assign by = in_req.sensor_y; assign bz = in_req.sensor_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0] <= aw*bw; t_q[1] <= ax*bx; t_q[2] <= ay*by; t_q[3] <= az*bz;
      t_q[4] <= aw*bx; t_q[5] <= ax*bw; t_q[6] <= ay*bz; t_q[7] <= az*by;
      t_q[8] <= aw*by; t_q[9] <= ax*bz; t_q[10] <= ay*bw; t_q[11] <= az*bx;
      t_q[12] <= aw*bz; t_q[13] <= ax*by; t_q[14] <= ay*bx; t_q[15] <= az*bw;
      sx2_q <= bx*bx; sy2_q <= by*by;
    end
  end

  // stage 2: sum and round to q18
  logic signed [34:0] sw, sx, sy, sz;
  logic signed [24:0] pw_q, px_q, py_q, pz_q;
  logic east_q [Lat-2];
  logic signed [34:0] cosr;
  always_comb begin
    sw = 35'(t_q[0]) - 35'(t_q[1]) - 35'(t_q[2]) - 35'(t_q[3]) + 35'sd512;
    sx = 35'(t_q[4]) + 35'(t_q[5]) + 35'(t_q[6]) - 35'(t_q[7]) + 35'sd512;
    sy = 35'(t_q[8]) - 35'(t_q[9]) + 35'(t_q[10]) + 35'(t_q[11]) + 35'sd512;
    sz = 35'(t_q[12]) + 35'(t_q[13]) - 35'(t_q[14]) + 35'(t_q[15]) + 35'sd512;
    cosr = (35'sd1 <<< (2*QUAT_FRAC_BITS)) - 35'(sx2_q) * 2 - 35'(sy2_q) * 2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= 25'(sw >>> 10); px_q <= 25'(sx >>> 10);
      py_q <= 25'(sy >>> 10); pz_q <= 25'(sz >>> 10);
      east_q[0] <= (cosr >= 0);
      for (int i = 1; i < Lat - 2; i++) east_q[i] <= east_q[i-1];
    end
  end

  // stage 3: direction vector in q36
  logic signed [49:0] ww, xx, yy, zz, xy, wz, xz, wy;
  logic signed [VecBits-1:0] dx_q, dy_q, dz_q;
  logic near_q;
  logic [51:0] nsum;
  always_comb begin
    ww = pw_q*pw_q; xx = px_q*px_q; yy = py_q*py_q; zz = pz_q*pz_q;
    xy = px_q*py_q; wz = pw_q*pz_q; xz = px_q*pz_q; wy = pw_q*py_q;
    nsum = 52'(ww) + 52'(xx) + 52'(yy) + 52'(zz);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      near_q <= (nsum <= 52'(NearZeroQ36));
      dx_q <= VecBits'(ww) + VecBits'(xx) - VecBits'(yy) - VecBits'(zz);
      dy_q <= (VecBits'(xy) + VecBits'(wz)) <<< 1;
      dz_q <= (VecBits'(xz) - VecBits'(wy)) <<< 1;
    end
  end

  // azimuth row; dz and near flag ride alongside
  logic [AccBits-1:0] az_acc;
  logic signed [VecBits-1:0] az_mag;
  qaa_cordic_chain u_az (
    .clk_i(clk_i), .en_i(en), .x_i(dy_q), .y_i(dx_q), .acc_o(az_acc), .mag_o(az_mag)
  );

  logic signed [VecBits-1:0] dz_dly [CordicSteps];
  logic near_dly [2*CordicSteps+2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dz_dly[0] <= dz_q;
      for (int i = 1; i < CordicSteps; i++) dz_dly[i] <= dz_dly[i-1];
      near_dly[0] <= near_q;
      for (int i = 1; i < 2*CordicSteps + 2; i++) near_dly[i] <= near_dly[i-1];
    end
  end

  // magnitude scaling: multiply then round, split over two stages
  logic signed [VecBits-1:0] hyp_q, dz2_q, dz3_q;
  logic signed [69:0] prod_q;
  logic [AccBits-1:0] azacc_q, azacc2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 70'(az_mag) * 70'(signed'({1'b0, InvGainQ16}));
      dz2_q <= dz_dly[CordicSteps-1];
      azacc_q <= az_acc;
      hyp_q <= VecBits'((prod_q + 70'sd32768) >>> 16);
      dz3_q <= dz2_q;
      azacc2_q <= azacc_q;
    end
  end

  logic [AccBits-1:0] alt_acc;
  logic signed [VecBits-1:0] alt_mag;
  qaa_cordic_chain u_alt (
    .clk_i(clk_i), .en_i(en), .x_i(hyp_q), .y_i(dz3_q), .acc_o(alt_acc), .mag_o(alt_mag)
  );

  logic [AccBits-1:0] azd [CordicSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      azd[0] <= azacc2_q;
      for (int i = 1; i < CordicSteps; i++) azd[i] <= azd[i-1];
    end
  end

  logic [AccBits-1:0] alt_r, az_r;
  logic [ANGLE_BITS-1:0] alt_f, az_f;
  logic alt_near;
  always_comb begin
    alt_r = alt_acc + RoundHalf;
    az_r  = azd[CordicSteps-1] + RoundHalf;
    alt_f = alt_r[AccBits-1 -: ANGLE_BITS];
    az_f  = az_r[AccBits-1 -: ANGLE_BITS];
    alt_near = near_dly[2*CordicSteps+1] | (alt_mag == 52'sd1 && 1'b0);
  end

  // output register
  logic [15:0] alt_q, azo_q;
  logic        east_o_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      alt_q <= alt_near ? '0 : 16'(alt_f);
      azo_q <= alt_near ? '0 : 16'(az_f);
      east_o_q <= east_q[Lat-3];
    end
  end
  assign out_res.altitude   = alt_q;
  assign out_res.azimuth    = azo_q;
  assign out_res.scope_east = east_o_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.azimuth))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.ready == (!out_res.valid || out_res.ready))
    else $error("ready mismatch");
  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && alt_near |=> out_res.altitude == '0 && out_res.azimuth == '0)
    else $error("near-zero direction not cleared");
`endif

endmodule

// ----- test/qaa_angle_checker.sv -----
// checker: predicts altitude, azimuth and scope_east per sensor request and compares
`timescale 1ns / 1ps
module qaa_angle_checker
  import qaa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  qaa_in_if           in_mon,
  qaa_out_if          out_mon,
  output int          error_count_o,
  output int          pending_count_o
);

  typedef struct {
    logic [15:0] altitude;
    logic [15:0] azimuth;
    logic        scope_east;
  } angles_t;

  localparam logic [31:0] AtanTurn [0:29] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  logic signed [15:0] off_w, off_x, off_y, off_z;
  angles_t            expected_angles[$];
  int                 errors;

  assign error_count_o   = errors;
  assign pending_count_o = expected_angles.size();

  // vectoring rotation: angle of (x, y) in 2^-32 turn, raw magnitude out
  function automatic logic [31:0] vector_angle(input longint y, input longint x,
                                               output longint mag);
    logic [31:0] acc;
    longint      xs, ys;
    acc = '0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return acc;
    end
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + AtanTurn[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - AtanTurn[i];
      end
    end
    mag = x;
    return acc;
  endfunction

  function automatic logic [15:0] round_turn(input logic [31:0] acc);
    logic [31:0] r;
    r = (acc + 32'h00008000) >> 16;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(input longint bw, input longint bx,
                                             input longint by, input longint bz);
    angles_t res;
    longint  aw, ax, ay, az, pw, px, py, pz, n, dx, dy, dz, mag, hyp, cosr;
    aw = off_w;
    ax = off_x;
    ay = off_y;
    az = off_z;
    pw = (aw * bw - ax * bx - ay * by - az * bz + 512) >>> 10;
    px = (aw * bx + ax * bw + ay * bz - az * by + 512) >>> 10;
    py = (aw * by - ax * bz + ay * bw + az * bx + 512) >>> 10;
    pz = (aw * bz + ax * by - ay * bx + az * bw + 512) >>> 10;
    n  = pw * pw + px * px + py * py + pz * pz;
    res.altitude = '0;
    res.azimuth  = '0;
    if (n > 68719) begin
      dx = pw * pw + px * px - py * py - pz * pz;
      dy = 2 * (px * py + pw * pz);
      dz = 2 * (px * pz - pw * py);
      res.azimuth  = round_turn(vector_angle(dx, dy, mag));
      hyp          = (mag * 39797 + 32768) >>> 16;
      res.altitude = round_turn(vector_angle(dz, hyp, mag));
    end
    cosr = (64'sd1 << 28) - 2 * (bx * bx + by * by);
    res.scope_east = (cosr >= 0);
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_w <= 16'sd16384;
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOffsetW: off_w <= cfg_data_i;
        CfgOffsetX: off_x <= cfg_data_i;
        CfgOffsetY: off_y <= cfg_data_i;
        CfgOffsetZ: off_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t got, want;
    if (!rst_ni) begin
      errors = 0;
      expected_angles.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.altitude   = out_mon.altitude;
        got.azimuth    = out_mon.azimuth;
        got.scope_east = out_mon.scope_east;
        if (expected_angles.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_angles.pop_front();
          if (got.altitude !== want.altitude) begin
            $error("altitude: expected %0d actual %0d",
                   $signed(want.altitude), $signed(got.altitude));
            errors++;
          end
          if (got.azimuth !== want.azimuth) begin
            $error("azimuth: expected %0d actual %0d", want.azimuth, got.azimuth);
            errors++;
          end
          if (got.scope_east !== want.scope_east) begin
            $error("scope_east: expected %0d actual %0d",
                   want.scope_east, got.scope_east);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_angles.push_back(predict_angles(
          $signed(in_mon.sensor_w), $signed(in_mon.sensor_x),
          $signed(in_mon.sensor_y), $signed(in_mon.sensor_z)));
    end
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top: drives sensor requests, offsets and result stalls, gives the verdict
`timescale 1ns / 1ps
module tb_top;
  import qaa_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          tx_idle_pct, rx_idle_pct;
  int          error_count, pending_count;
  int          cycles = 0;

  qaa_in_if  in_req ();
  qaa_out_if out_res ();

  quaternion_to_alt_az_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_req     (in_req.sink),
    .out_res    (out_res.source)
  );

  qaa_angle_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_mon          (in_req),
    .out_mon         (out_res),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.sensor_w <= w;
    in_req.sensor_x <= x;
    in_req.sensor_y <= y;
    in_req.sensor_z <= z;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] w, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= CfgOffsetW; cfg_data <= w; @(posedge clk);
    cfg_idx <= CfgOffsetX; cfg_data <= x; @(posedge clk);
    cfg_idx <= CfgOffsetY; cfg_data <= y; @(posedge clk);
    cfg_idx <= CfgOffsetZ; cfg_data <= z; @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_component(input int kind);
    case (kind)
      0: return 16'($urandom_range(32768) - 16384);
      1: return 16'($urandom);
      default: return 16'($urandom_range(40) - 20);
    endcase
  endfunction

  task automatic send_random;
    int          kind, sel;
    logic [15:0] a, b;
    sel = $urandom_range(99);
    kind = (sel < 70) ? 0 : (sel < 85) ? 1 : (sel < 93) ? 2 : 3;
    if (kind == 3) begin
      a = pick_component(0);
      b = pick_component(0);
      // vertical pointing, or roll right at the quarter-turn edge
      if ($urandom_range(1))
        send_quat(a, 16'd0, a, 16'd0);
      else
        send_quat(a, 16'd8192, 16'(8192 - $urandom_range(1)), b);
    end else begin
      send_quat(pick_component(kind), pick_component(kind),
                pick_component(kind), pick_component(kind));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgOffsetW;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_req.valid = 1'b0;
    in_req.sensor_w = '0;
    in_req.sensor_x = '0;
    in_req.sensor_y = '0;
    in_req.sensor_z = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the identity offset
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'd0, 16'd0, 16'd0, 16'd0);
    send_quat(16'd10, 16'd0, 16'd0, 16'd0);
    send_quat(16'd16, 16'd3, 16'd0, 16'd0);
    send_quat(16'd17, 16'd0, 16'd0, 16'd0);
    send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
    send_quat(-16'sd16384, 16'd0, 16'd0, 16'd0);
    send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
    send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
    send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
    send_quat(16'd8192, 16'd0, 16'd8192, 16'd0);
    send_quat(16'd8192, 16'd0, -16'sd8192, 16'd0);
    send_quat(16'd0, 16'd8192, 16'd8192, 16'd0);
    send_quat(16'd0, 16'd8193, 16'd8192, 16'd0);
    send_quat(16'd16384, 16'd0, 16'd0, -16'sd1);
    send_quat(16'd16384, 16'd0, 16'd0, 16'd1);
    send_quat(16'd32000, 16'd100, 16'd200, 16'd300);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_offset(16'd16384, 16'd0, 16'd0, 16'd0);
        1: write_offset(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: write_offset(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        3: write_offset(16'd0, 16'd0, 16'd0, 16'd0);
        4: write_offset(16'(11585), 16'd0, 16'd0, 16'(11585));
        default: write_offset(pick_component(1), pick_component(1),
                              pick_component(1), pick_component(1));
      endcase
      tx_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 55 : 0;
      rx_idle_pct = (phase < 2) ? 55 : (phase < 4) ? 30 : 0;
      for (int i = 0; i < 150; i++) send_random();
    end
    in_req.valid <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qaa_pkg.sv
rtl/core/qaa_if.sv
rtl/core/qaa_cordic_cell.sv
rtl/core/qaa_cordic_chain.sv
rtl/core/quaternion_to_alt_az_core.sv
test/qaa_angle_checker.sv
test/tb_top.sv
